>>> rtl/i2cmbe_pkg.sv
package i2cmbe_pkg;

    // Command codes carried in the operation field
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_CHKACK = 3'd4,
        OP_ACK   = 3'd5,
        OP_NACK  = 3'd6
    } op_t;

    // Bus phase sequencer, one-hot
    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_1       = 8'b0000_0010,
        PH_2       = 8'b0000_0100,
        PH_3       = 8'b0000_1000,
        PH_4       = 8'b0001_0000,
        PH_TOSTOP  = 8'b0010_0000,
        PH_TOSTOP2 = 8'b0100_0000,
        PH_POLL    = 8'b1000_0000
    } phase_t;

    // Register indexes (byte address is 4 * index)
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd2;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd200;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

    // One tick of input
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] operation;
        logic [7:0] write_data;
        logic       sda_in;
    } in_item_t;

    // One tick of result
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_oe;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_ok;
    } out_item_t;

endpackage

>>> rtl/i2c_master_bit_engine_core.sv
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | in_item_t  (command, write byte, sampled SDA)
// m_       | out       | m_valid / m_ready  | out_item_t (pins, busy, done, read byte, ack)
// APB      | in        | psel/penable/pready| half_period_ticks @0x0, ack_timeout @0x4
//
// One tick per clock while m_ready keeps up: each transfer is processed by the phase
// sequencer and its result lands in the output register the same edge.
// s_ready is high while the output register is empty or being drained, so a new
// tick is taken every cycle as long as m_ready keeps up.
// Reset (aresetn, synchronous) puts the engine idle with SCL/SDA high and driven.
module i2c_master_bit_engine_core
    import i2cmbe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_payload,

    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_payload,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [15:0] half_period_reg;
    logic [7:0]  ack_timeout_reg;

    // Engine state
    phase_t      phase_reg, phase_next;
    op_t         cmd_reg, cmd_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  poll_count_reg, poll_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        oe_reg, oe_next;
    logic [7:0]  last_read_reg, last_read_next;
    logic        ack_flag_reg, ack_flag_next;
    logic        done;

    // Output register
    logic        m_valid_reg;
    out_item_t   m_payload_reg;

    logic        s_fire;
    logic        cfg_write;
    logic [16:0] tick_inc;
    logic        phase_over;
    logic [3:0]  bit_inc;
    logic [7:0]  shift_left;
    logic [7:0]  shift_in;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // APB access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_HALF_PERIOD: prdata = {16'd0, half_period_reg};
            REG_ACK_TIMEOUT: prdata = {24'd0, ack_timeout_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_HALF_PERIOD) begin
                half_period_reg <= pwdata[15:0];
            end else begin
                ack_timeout_reg <= pwdata[7:0];
            end
        end
    end

    // Phase timing and shift helpers
    assign tick_inc   = {1'b0, tick_count_reg} + 17'd1;
    assign phase_over = tick_inc >= {1'b0, half_period_reg};
    assign bit_inc    = bit_count_reg + 4'd1;
    assign shift_left = {shift_reg[6:0], 1'b0};
    assign shift_in   = {shift_reg[6:0], s_payload.sda_in};

    // Next-state logic for one tick
    always_comb begin
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        bit_count_next  = bit_count_reg;
        tick_count_next = tick_count_reg;
        poll_count_next = poll_count_reg;
        shift_next      = shift_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        oe_next         = oe_reg;
        last_read_next  = last_read_reg;
        ack_flag_next   = ack_flag_reg;
        done            = 1'b0;

        case (phase_reg)
            // Launch a new command; code 7 is dropped
            PH_IDLE: begin
                if (s_payload.cmd_valid && s_payload.operation <= OP_NACK) begin
                    cmd_next        = op_t'(s_payload.operation);
                    bit_count_next  = '0;
                    poll_count_next = '0;
                    case (op_t'(s_payload.operation))
                        OP_START: begin
                            oe_next = 1'b1; scl_next = 1'b1; sda_next = 1'b1;
                        end
                        OP_STOP: begin
                            oe_next = 1'b1; scl_next = 1'b1; sda_next = 1'b0;
                        end
                        OP_WRITE: begin
                            shift_next = s_payload.write_data;
                            oe_next = 1'b1; scl_next = 1'b0;
                        end
                        OP_READ: begin
                            shift_next = '0;
                            oe_next = 1'b0; scl_next = 1'b0;
                        end
                        OP_CHKACK: begin
                            oe_next = 1'b0; sda_next = 1'b1;
                        end
                        default: begin
                            oe_next = 1'b1; scl_next = 1'b0;
                        end
                    endcase
                    phase_next      = PH_1;
                    tick_count_next = '0;
                end
            end

            // Ack wait: one SDA sample per tick
            PH_POLL: begin
                if (!s_payload.sda_in) begin
                    scl_next      = 1'b0;
                    ack_flag_next = 1'b1;
                    done          = 1'b1;
                end else if (poll_count_reg >= ack_timeout_reg) begin
                    oe_next = 1'b1; scl_next = 1'b1; sda_next = 1'b0;
                    phase_next      = PH_TOSTOP;
                    tick_count_next = '0;
                end else begin
                    poll_count_next = poll_count_reg + 8'd1;
                end
            end

            // Timed phases
            default: begin
                if (!phase_over) begin
                    tick_count_next = tick_inc[15:0];
                end else begin
                    tick_count_next = '0;
                    if (phase_reg == PH_TOSTOP) begin
                        sda_next   = 1'b1;
                        phase_next = PH_TOSTOP2;
                    end else if (phase_reg == PH_TOSTOP2) begin
                        ack_flag_next = 1'b0;
                        done          = 1'b1;
                    end else begin
                        case (cmd_reg)
                            OP_START, OP_STOP: begin
                                if (phase_reg == PH_1) begin
                                    sda_next   = (cmd_reg == OP_STOP);
                                    phase_next = PH_2;
                                end else begin
                                    done = 1'b1;
                                end
                            end
                            OP_WRITE: begin
                                if (phase_reg == PH_1) begin
                                    sda_next   = shift_reg[7];
                                    phase_next = PH_2;
                                end else if (phase_reg == PH_2) begin
                                    scl_next   = 1'b1;
                                    phase_next = PH_3;
                                end else if (phase_reg == PH_3) begin
                                    scl_next   = 1'b0;
                                    phase_next = PH_4;
                                end else begin
                                    bit_count_next = bit_inc;
                                    shift_next     = shift_left;
                                    if (bit_inc >= BITS_PER_BYTE) begin
                                        done = 1'b1;
                                    end else begin
                                        sda_next   = shift_left[7];
                                        phase_next = PH_2;
                                    end
                                end
                            end
                            OP_READ: begin
                                if (phase_reg == PH_1) begin
                                    scl_next   = 1'b1;
                                    phase_next = PH_2;
                                end else begin
                                    shift_next     = shift_in;
                                    bit_count_next = bit_inc;
                                    if (bit_inc >= BITS_PER_BYTE) begin
                                        last_read_next = shift_in;
                                        done           = 1'b1;
                                    end else begin
                                        scl_next   = 1'b0;
                                        phase_next = PH_1;
                                    end
                                end
                            end
                            OP_CHKACK: begin
                                if (phase_reg == PH_1) begin
                                    scl_next   = 1'b1;
                                    phase_next = PH_2;
                                end else begin
                                    poll_count_next = '0;
                                    phase_next      = PH_POLL;
                                end
                            end
                            default: begin
                                // send ack / send nack
                                if (phase_reg == PH_1) begin
                                    sda_next   = (cmd_reg == OP_NACK);
                                    phase_next = PH_2;
                                end else if (phase_reg == PH_2) begin
                                    scl_next   = 1'b1;
                                    phase_next = PH_3;
                                end else begin
                                    if (cmd_reg == OP_ACK) begin
                                        scl_next = 1'b0;
                                    end
                                    done = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
        endcase

        if (done) begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
        end
    end

    // State update on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            cmd_reg        <= OP_START;
            bit_count_reg  <= '0;
            tick_count_reg <= '0;
            poll_count_reg <= '0;
            shift_reg      <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            oe_reg         <= 1'b1;
            last_read_reg  <= '0;
            ack_flag_reg   <= 1'b0;
        end else if (s_fire) begin
            phase_reg      <= phase_next;
            cmd_reg        <= cmd_next;
            bit_count_reg  <= bit_count_next;
            tick_count_reg <= tick_count_next;
            poll_count_reg <= poll_count_next;
            shift_reg      <= shift_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            oe_reg         <= oe_next;
            last_read_reg  <= last_read_next;
            ack_flag_reg   <= ack_flag_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_payload_reg.scl       <= scl_next;
            m_payload_reg.sda_out   <= sda_next;
            m_payload_reg.sda_oe    <= oe_next;
            m_payload_reg.busy_res  <= (phase_next != PH_IDLE);
            m_payload_reg.done_res  <= done;
            m_payload_reg.read_data <= last_read_next;
            m_payload_reg.ack_ok    <= ack_flag_next;
        end
    end

endmodule

>>> tb/tb_i2c_master_bit_engine_core.sv
module tb_i2c_master_bit_engine_core
    import i2cmbe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Operation code with no command behind it
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int PHASE_TICKS = 70;
    localparam int RANDOM_PHASES = 9;
    localparam int NO_LIMIT = 1 << 20;
    localparam int DRAIN_LIMIT = 4000;

    // Predicts the bus engine tick by tick and checks the result stream
    class i2c_tick_scoreboard;
        bit [15:0]   half_period;
        bit [7:0]    ack_limit;
        phase_t      phase;
        op_t         cmd;
        bit [3:0]    bit_cnt;
        bit [15:0]   ticks;
        bit [7:0]    polls;
        bit [7:0]    shreg;
        bit          scl_q;
        bit          sda_q;
        bit          oe_q;
        bit [7:0]    read_byte;
        bit          ack_q;
        out_item_t   expected_ticks[$];
        int          errors;
        int          items;
        int          checked;
        int          finished;
        int          acks;
        int          timeouts;

        function new();
            half_period = HALF_PERIOD_RESET;
            ack_limit   = ACK_TIMEOUT_RESET;
            phase       = PH_IDLE;
            cmd         = OP_START;
            bit_cnt     = '0;
            ticks       = '0;
            polls       = '0;
            shreg       = '0;
            scl_q       = 1'b1;
            sda_q       = 1'b1;
            oe_q        = 1'b1;
            read_byte   = '0;
            ack_q       = 1'b0;
            errors      = 0;
            items       = 0;
            checked     = 0;
            finished    = 0;
            acks        = 0;
            timeouts    = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_HALF_PERIOD) begin
                half_period = value[15:0];
            end else begin
                ack_limit = value[7:0];
            end
        endfunction

        function void enter(phase_t p);
            phase = p;
            ticks = '0;
        endfunction

        function bit busy();
            return phase != PH_IDLE;
        endfunction

        function bit polling();
            return phase == PH_POLL;
        endfunction

        function bit acked();
            return ack_q;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        // A timed phase ran out; returns 1 when the command is finished
        function bit phase_elapsed(bit sda);
            if (phase == PH_TOSTOP) begin
                sda_q = 1'b1;
                enter(PH_TOSTOP2);
                return 1'b0;
            end
            if (phase == PH_TOSTOP2) begin
                ack_q = 1'b0;
                return 1'b1;
            end
            case (cmd)
                OP_START, OP_STOP: begin
                    if (phase == PH_1) begin
                        sda_q = (cmd == OP_STOP);
                        enter(PH_2);
                        return 1'b0;
                    end
                    return 1'b1;
                end
                OP_WRITE: begin
                    if (phase == PH_1) begin
                        sda_q = shreg[7];
                        enter(PH_2);
                        return 1'b0;
                    end
                    if (phase == PH_2) begin
                        scl_q = 1'b1;
                        enter(PH_3);
                        return 1'b0;
                    end
                    if (phase == PH_3) begin
                        scl_q = 1'b0;
                        enter(PH_4);
                        return 1'b0;
                    end
                    bit_cnt = bit_cnt + 4'd1;
                    shreg = shreg << 1;
                    if (bit_cnt >= BITS_PER_BYTE) return 1'b1;
                    sda_q = shreg[7];
                    enter(PH_2);
                    return 1'b0;
                end
                OP_READ: begin
                    if (phase == PH_1) begin
                        scl_q = 1'b1;
                        enter(PH_2);
                        return 1'b0;
                    end
                    // sample at the end of the SCL-high phase
                    shreg = {shreg[6:0], sda};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= BITS_PER_BYTE) begin
                        read_byte = shreg;
                        return 1'b1;
                    end
                    scl_q = 1'b0;
                    enter(PH_1);
                    return 1'b0;
                end
                OP_CHKACK: begin
                    if (phase == PH_1) begin
                        scl_q = 1'b1;
                        enter(PH_2);
                        return 1'b0;
                    end
                    polls = '0;
                    enter(PH_POLL);
                    return 1'b0;
                end
                default: begin
                    // send ack / send nack
                    if (phase == PH_1) begin
                        sda_q = (cmd == OP_NACK);
                        enter(PH_2);
                        return 1'b0;
                    end
                    if (phase == PH_2) begin
                        scl_q = 1'b1;
                        enter(PH_3);
                        return 1'b0;
                    end
                    if (cmd == OP_ACK) scl_q = 1'b0;
                    return 1'b1;
                end
            endcase
        endfunction

        // Advance the engine by one accepted tick and queue its result
        function void record_tick(in_item_t it);
            bit [16:0] next_tick;
            bit        done;
            out_item_t exp;
            done = 1'b0;
            items++;
            if (phase == PH_IDLE) begin
                if (it.cmd_valid && it.operation != OP_UNUSED) begin
                    cmd = op_t'(it.operation);
                    bit_cnt = '0;
                    polls = '0;
                    case (cmd)
                        OP_START: begin
                            oe_q = 1'b1; scl_q = 1'b1; sda_q = 1'b1;
                        end
                        OP_STOP: begin
                            oe_q = 1'b1; scl_q = 1'b1; sda_q = 1'b0;
                        end
                        OP_WRITE: begin
                            shreg = it.write_data;
                            oe_q = 1'b1; scl_q = 1'b0;
                        end
                        OP_READ: begin
                            shreg = '0;
                            oe_q = 1'b0; scl_q = 1'b0;
                        end
                        OP_CHKACK: begin
                            oe_q = 1'b0; sda_q = 1'b1;
                        end
                        default: begin
                            oe_q = 1'b1; scl_q = 1'b0;
                        end
                    endcase
                    enter(PH_1);
                end
            end else if (phase == PH_POLL) begin
                if (!it.sda_in) begin
                    scl_q = 1'b0;
                    ack_q = 1'b1;
                    done = 1'b1;
                    acks++;
                end else if (polls >= ack_limit) begin
                    // give up: drive a stop condition
                    oe_q = 1'b1; scl_q = 1'b1; sda_q = 1'b0;
                    enter(PH_TOSTOP);
                    timeouts++;
                end else begin
                    polls = polls + 8'd1;
                end
            end else begin
                next_tick = {1'b0, ticks} + 17'd1;
                if (next_tick >= {1'b0, half_period}) begin
                    done = phase_elapsed(it.sda_in);
                end else begin
                    ticks = next_tick[15:0];
                end
            end
            if (done) begin
                enter(PH_IDLE);
                finished++;
            end
            exp.scl       = scl_q;
            exp.sda_out   = sda_q;
            exp.sda_oe    = oe_q;
            exp.busy_res  = (phase != PH_IDLE);
            exp.done_res  = done;
            exp.read_data = read_byte;
            exp.ack_ok    = ack_q;
            expected_ticks.push_back(exp);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task check_tick(out_item_t got);
            out_item_t exp;
            string     diff;
            if (expected_ticks.size() == 0) begin
                report("result transfer with nothing expected");
                return;
            end
            exp = expected_ticks.pop_front();
            checked++;
            diff = "";
            if (got.scl !== exp.scl) diff = {diff, " scl"};
            if (got.sda_out !== exp.sda_out) diff = {diff, " sda_out"};
            if (got.sda_oe !== exp.sda_oe) diff = {diff, " sda_oe"};
            if (got.busy_res !== exp.busy_res) diff = {diff, " busy"};
            if (got.done_res !== exp.done_res) diff = {diff, " done"};
            if (got.read_data !== exp.read_data) diff = {diff, " read_data"};
            if (got.ack_ok !== exp.ack_ok) diff = {diff, " ack_ok"};
            if (diff != "") begin
                report($sformatf("result %0d:%s (got %h, expected %h)",
                                 checked, diff, got, exp));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    out_item_t   m_payload;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_tick_scoreboard sb = new();
    bit idle_on = 1'b1;
    bit quiet = 1'b0;
    bit s_valid_set = 1'b0;
    int stall_left = 0;
    int reg_writes = 0;

    i2c_master_bit_engine_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 aclk = ~aclk;

    // Result side: random stall bursts
    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 15);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_tick(m_payload);
    end

    function automatic in_item_t random_tick();
        in_item_t it;
        it.cmd_valid  = 1'($urandom);
        it.operation  = 3'($urandom);
        it.write_data = 8'($urandom);
        it.sda_in     = 1'($urandom);
        return it;
    endfunction

    // Where the slave pulls SDA low during the ack poll; -1 never
    function automatic int pick_ack_delay();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(0, 3);
        if (r < 8) return $urandom_range(0, sb.ack_limit + 1);
        return -1;
    endfunction

    // One tick transfer, with an optional gap first
    task automatic send_tick(input in_item_t it);
        if (idle_on && $urandom_range(0, 11) == 0) begin
            if (s_valid_set) s_valid <= 1'b0;
            s_valid_set = 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= it;
        s_valid_set = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.record_tick(it);
    endtask

    // Pause the sender until every result is back
    task automatic drain();
        if (s_valid_set) s_valid <= 1'b0;
        s_valid_set = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Both registers back to back, psel held across the two transfers
    task automatic apb_config(input logic [15:0] hp, input logic [7:0] tmo);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_HALF_PERIOD, 2'b00};
        pwdata <= {16'd0, hp};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(REG_HALF_PERIOD, {16'd0, hp});
        penable <= 1'b0;
        paddr <= {REG_ACK_TIMEOUT, 2'b00};
        pwdata <= {24'd0, tmo};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(REG_ACK_TIMEOUT, {24'd0, tmo});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_writes += 2;
    endtask

    // Ticks while the engine works; SDA answers the ack poll at ack_delay
    task automatic busy_ticks(input int max_ticks, input int ack_delay);
        in_item_t it;
        int       polls_seen;
        int       n;
        polls_seen = 0;
        n = 0;
        while (sb.busy() && n < max_ticks) begin
            it = random_tick();
            // commands while busy are ignored, send a few anyway
            it.cmd_valid = ($urandom_range(0, 7) == 0);
            if (sb.polling()) begin
                it.sda_in = (polls_seen == ack_delay) ? 1'b0 : 1'b1;
                polls_seen++;
            end
            send_tick(it);
            n++;
        end
    endtask

    task automatic run_cmd(input logic [2:0] op, input logic [7:0] wdata, input int ack_delay);
        in_item_t it;
        repeat ($urandom_range(0, 2)) begin
            it = random_tick();
            if (it.cmd_valid) it.operation = OP_UNUSED;
            send_tick(it);
        end
        it = random_tick();
        it.cmd_valid = 1'b1;
        it.operation = op;
        it.write_data = wdata;
        send_tick(it);
        busy_ticks(NO_LIMIT, ack_delay);
    endtask

    // Well-formed bus transaction: address, then a few data bytes
    task automatic run_transfer();
        int nbytes;
        bit rd;
        nbytes = $urandom_range(1, 3);
        rd = 1'($urandom);
        run_cmd(OP_START, 8'($urandom), 0);
        run_cmd(OP_WRITE, {7'($urandom), rd}, 0);
        run_cmd(OP_CHKACK, 8'($urandom), pick_ack_delay());
        // on a timeout the engine has already released the bus
        if (!sb.acked()) return;
        for (int i = 0; i < nbytes; i++) begin
            if (rd) begin
                run_cmd(OP_READ, 8'($urandom), 0);
                run_cmd((i == nbytes - 1) ? OP_NACK : OP_ACK, 8'($urandom), 0);
            end else begin
                run_cmd(OP_WRITE, 8'($urandom), 0);
                run_cmd(OP_CHKACK, 8'($urandom), pick_ack_delay());
                if (!sb.acked()) return;
            end
        end
        run_cmd(OP_STOP, 8'($urandom), 0);
    endtask

    initial begin
        in_item_t    it;
        int          base;
        logic [15:0] hp;
        logic [7:0]  tmo;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: undefined op, reset settings, then each command
        run_cmd(OP_UNUSED, 8'h00, 0);
        run_cmd(OP_START, 8'hFF, 0);
        drain();
        apb_config(16'd1, 8'd0);
        run_cmd(OP_WRITE, 8'hFF, 0);
        run_cmd(OP_CHKACK, 8'h00, 0);
        run_cmd(OP_WRITE, 8'h00, 0);
        run_cmd(OP_CHKACK, 8'hFF, -1);   // zero timeout gives up at once
        run_cmd(OP_START, 8'h00, 0);
        run_cmd(OP_READ, 8'h00, 0);
        run_cmd(OP_ACK, 8'h00, 0);
        run_cmd(OP_READ, 8'hFF, 0);
        run_cmd(OP_NACK, 8'h00, 0);
        run_cmd(OP_STOP, 8'h00, 0);
        // longest timeout, never acked
        drain();
        apb_config(16'd1, 8'd255);
        run_cmd(OP_CHKACK, 8'h00, -1);
        // zero half period behaves as one tick
        drain();
        apb_config(16'd0, 8'd255);
        run_cmd(OP_STOP, 8'h00, 0);

        // Half period changed in the middle of a write byte
        drain();
        apb_config(16'd3, 8'd2);
        it = random_tick();
        it.cmd_valid = 1'b1;
        it.operation = OP_WRITE;
        it.write_data = 8'hA5;
        send_tick(it);
        busy_ticks(5, 0);
        drain();
        apb_config(16'd65535, 8'd2);
        busy_ticks(20, 0);
        drain();
        apb_config(16'd1, 8'd2);
        busy_ticks(NO_LIMIT, 0);

        // Random: transactions with some stray commands, one setting per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin hp = 16'd1; tmo = 8'd0; end
                1: begin hp = 16'd2; tmo = 8'd255; end
                2: begin hp = 16'd3; tmo = 8'd1; end
                3: begin hp = 16'd0; tmo = 8'd3; end
                4: begin hp = 16'd4; tmo = 8'd200; end
                default: begin
                    hp = 16'($urandom_range(1, 3));
                    tmo = 8'($urandom_range(0, 6));
                end
            endcase
            apb_config(hp, tmo);
            quiet = (ph == RANDOM_PHASES - 1);
            idle_on = !quiet && ($urandom_range(0, 3) != 0);
            base = sb.items;
            while (sb.items - base < PHASE_TICKS) begin
                if ($urandom_range(0, 5) == 0) begin
                    run_cmd(3'($urandom), 8'($urandom), pick_ack_delay());
                end else begin
                    run_transfer();
                end
                if ($urandom_range(0, 9) == 0) drain();
                if ($urandom_range(0, 3) == 0) idle_on = !quiet && !idle_on;
            end
        end

        // Wind down: wait out every outstanding result
        if (s_valid_set) s_valid <= 1'b0;
        s_valid_set = 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && sb.pending() != 0; w++) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        end
        repeat (4) @(posedge aclk);

        $display("Ran %0d ticks through %0d register writes; %0d results checked.",
                 sb.items, reg_writes, sb.checked);
        $display("Engine finished %0d commands, %0d acked polls, %0d ack timeouts.",
                 sb.finished, sb.acks, sb.timeouts);
        if (sb.errors == 0) begin
            $display("i2c_master_bit_engine_core verification clean");
        end else begin
            $display("i2c_master_bit_engine_core verification failed");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #4000000;
        $display("Timeout: stimulus or results stalled");
        $display("i2c_master_bit_engine_core verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/i2cmbe_pkg.sv
rtl/i2c_master_bit_engine_core.sv
tb/tb_i2c_master_bit_engine_core.sv
